// File: rtl/core/penalized_weighted_random_pick_assert.svh
// Assertion macros for the port-level checker.
`ifndef PENALIZED_WEIGHTED_RANDOM_PICK_ASSERT_SVH
`define PENALIZED_WEIGHTED_RANDOM_PICK_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define PWRP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define PWRP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/pwrp_pkg.sv
// Package with constants and types for the weighted random pick.
package pwrp_pkg;

    localparam int DefMaxEntries = 64;
    localparam int DefWeightBits = 24;
    localparam int CfgIdxBits    = 3;
    localparam int IndexOutBits  = 6;

    localparam logic [CfgIdxBits-1:0] CFG_ENTRY_COUNT = 3'd0;
    localparam logic [CfgIdxBits-1:0] CFG_TIME_BASED  = 3'd1;
    localparam logic [CfgIdxBits-1:0] CFG_PENALTY     = 3'd2;
    localparam logic [CfgIdxBits-1:0] CFG_RESTORE     = 3'd3;
    localparam logic [CfgIdxBits-1:0] CFG_MIN_ELAPSED = 3'd4;
    localparam logic [CfgIdxBits-1:0] CFG_MAX_ELAPSED = 3'd5;

    localparam logic FUNC_PICK  = 1'b0;
    localparam logic FUNC_RESET = 1'b1;

    // Configuration values handed from the top level to the engine.
    typedef struct packed {
        logic [6:0]  entry_count;
        logic        time_based;
        logic [15:0] selection_penalty;
        logic [15:0] restore_rate;
        logic [15:0] min_elapsed;
        logic [15:0] max_elapsed;
    } pwrp_cfg_t;

endpackage

// File: rtl/core/pwrp_engine.sv
// Sequencer and weight memory: fill, restore, sum, boost and select passes and the penalty write.
module pwrp_engine
    import pwrp_pkg::*;
#(
    parameter int MAX_ENTRIES = DefMaxEntries,
    parameter int WEIGHT_BITS = DefWeightBits
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  pwrp_cfg_t               cfg,
    input  logic                    fill_req,
    input  logic                    start,
    input  logic                    func,
    input  logic [15:0]             random_fraction,
    input  logic [15:0]             elapsed_time,
    output logic                    busy,
    output logic                    done,
    output logic [IndexOutBits-1:0] chosen_index,
    output logic                    weights_boosted
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int SW = WEIGHT_BITS + AW + 1;
    localparam int EW = WEIGHT_BITS + 2;
    localparam logic signed [EW-1:0] WMAX = EW'((64'sd1 <<< (WEIGHT_BITS-1)) - 1);
    localparam logic signed [EW-1:0] WMIN = -WMAX - EW'(1);
    localparam logic signed [EW-1:0] ONE  = EW'(65536) > WMAX ? WMAX : EW'(65536);
    // Any step this large already drives every weight to the rail.
    localparam logic [EW-1:0]        GCAP = EW'((64'sd1 <<< WEIGHT_BITS) - 1);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_FILL    = 8'b0000_0010,
        ST_RESTORE = 8'b0000_0100,
        ST_SUM     = 8'b0000_1000,
        ST_BOOST   = 8'b0001_0000,
        ST_TARGET  = 8'b0010_0000,
        ST_SELECT  = 8'b0100_0000,
        ST_PENAL   = 8'b1000_0000
    } st_t;

    // Weight memory: one write port, one registered read port.
    logic [WEIGHT_BITS-1:0] mem [MAX_ENTRIES];
    logic [AW-1:0]          rd_addr, wr_addr;
    logic                   wr_en;
    logic [WEIGHT_BITS-1:0] wr_data, rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    st_t                   state_reg, state_next;
    logic [CW-1:0]         rcnt_reg, rcnt_next;   // read pointer
    logic [CW-1:0]         wcnt_reg, wcnt_next;   // data pointer (one behind)
    logic                  rv_reg, rv_next;       // read data is valid
    logic signed [EW-1:0]  gain_reg, gain_next;
    logic [SW-1:0]         sum_reg, sum_next;
    logic signed [EW-1:0]  maxw_reg, maxw_next;
    logic [SW+15:0]        target_reg, target_next;
    logic [AW-1:0]         pick_reg, pick_next;
    logic                  found_reg, found_next;
    logic                  boost_reg, boost_next;
    logic                  done_reg, done_next;
    logic                  fill_cmd_reg, fill_cmd_next;  // fill answers a reset command
    logic                  picked_reg;
    logic [15:0]           rnd_reg, el_reg;
    logic [15:0]           dt;
    logic [CW-1:0]         n;
    logic [CW-1:0]         last;
    logic signed [EW-1:0]  w, wsum, wsat;
    logic [SW-1:0]         wpos;
    logic [32:0]           gain_prod, pen_wide;

    // Limits an unsigned step to the largest one that still matters.
    function automatic logic signed [EW-1:0] cap_gain(input logic [32:0] v);
        return (v > 33'(GCAP)) ? GCAP : EW'(v);
    endfunction

    // Active entry count limited to capacity.
    assign n = (CW'(cfg.entry_count) > CW'(MAX_ENTRIES) || 32'(cfg.entry_count) > MAX_ENTRIES)
               ? CW'(MAX_ENTRIES) : CW'(cfg.entry_count);
    assign last = n - CW'(1);

    always_comb
    begin
        if (!cfg.time_based)
            dt = 16'd256;
        else if (el_reg < cfg.min_elapsed)
            dt = cfg.min_elapsed;
        else if (el_reg > cfg.max_elapsed)
            dt = cfg.max_elapsed;
        else
            dt = el_reg;
    end

    assign gain_prod = 33'(dt) * 33'(cfg.restore_rate);
    assign pen_wide  = 33'({cfg.selection_penalty, 8'd0});

    // Saturating add of the current gain to the word just read.
    assign w    = EW'($signed(rd_data_reg));
    assign wsum = w + gain_reg;
    assign wsat = (wsum > WMAX) ? WMAX : ((wsum < WMIN) ? WMIN : wsum);
    assign wpos = (w > 0) ? SW'(rd_data_reg) : '0;

    always_comb
    begin
        state_next    = state_reg;
        rcnt_next     = rcnt_reg;
        wcnt_next     = wcnt_reg;
        rv_next       = 1'b0;
        gain_next     = gain_reg;
        sum_next      = sum_reg;
        maxw_next     = maxw_reg;
        target_next   = target_reg;
        pick_next     = pick_reg;
        found_next    = found_reg;
        boost_next    = boost_reg;
        done_next     = 1'b0;
        fill_cmd_next = fill_cmd_reg;
        rd_addr       = rcnt_reg[AW-1:0];
        wr_en         = 1'b0;
        wr_addr       = wcnt_reg[AW-1:0];
        wr_data       = wsat[WEIGHT_BITS-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                rcnt_next = '0;
                wcnt_next = '0;
                if (fill_req)
                begin
                    state_next    = ST_FILL;
                    fill_cmd_next = 1'b0;
                end
                else if (start)
                begin
                    boost_next    = 1'b0;
                    fill_cmd_next = (func == FUNC_RESET);
                    if (func == FUNC_RESET)
                        state_next = ST_FILL;
                    else if (n < CW'(2))
                        done_next = 1'b1;
                    else
                        state_next = ST_RESTORE;
                    gain_next = '0;
                end
            end
            ST_FILL:
            begin
                wr_en     = 1'b1;
                wr_addr   = wcnt_reg[AW-1:0];
                wr_data   = ONE[WEIGHT_BITS-1:0];
                wcnt_next = wcnt_reg + CW'(1);
                if (wcnt_reg == CW'(MAX_ENTRIES - 1))
                begin
                    state_next = ST_IDLE;
                    done_next  = fill_cmd_reg;
                end
            end
            ST_RESTORE, ST_BOOST:
            begin
                // First restore visit computes the gain; read and write back behind.
                if (state_reg == ST_RESTORE && rcnt_reg == '0 && !rv_reg)
                    gain_next = cap_gain(gain_prod);
                if (rcnt_reg < n)
                begin
                    rcnt_next = rcnt_reg + CW'(1);
                    rv_next   = 1'b1;
                end
                if (rv_reg)
                begin
                    wr_en     = 1'b1;
                    wcnt_next = wcnt_reg + CW'(1);
                    if (wcnt_reg == last)
                    begin
                        state_next = ST_SUM;
                        rcnt_next  = '0;
                        wcnt_next  = '0;
                        rv_next    = 1'b0;
                        sum_next   = '0;
                        maxw_next  = WMIN;
                    end
                end
            end
            ST_SUM:
            begin
                if (rcnt_reg < n)
                begin
                    rcnt_next = rcnt_reg + CW'(1);
                    rv_next   = 1'b1;
                end
                if (rv_reg)
                begin
                    sum_next  = sum_reg + wpos;
                    maxw_next = (w > maxw_reg) ? w : maxw_reg;
                    wcnt_next = wcnt_reg + CW'(1);
                    if (wcnt_reg == last)
                    begin
                        rcnt_next = '0;
                        wcnt_next = '0;
                        rv_next   = 1'b0;
                        if (sum_reg + wpos == '0 && !boost_reg)
                        begin
                            boost_next = 1'b1;
                            gain_next  = ONE - ((w > maxw_reg) ? w : maxw_reg);
                            state_next = ST_BOOST;
                        end
                        else
                        begin
                            state_next = ST_TARGET;
                        end
                    end
                end
            end
            ST_TARGET:
            begin
                target_next = (SW+16)'(sum_reg) * (SW+16)'(rnd_reg);
                sum_next    = '0;
                found_next  = 1'b0;
                pick_next   = last[AW-1:0];
                state_next  = ST_SELECT;
            end
            ST_SELECT:
            begin
                if (rcnt_reg < n)
                begin
                    rcnt_next = rcnt_reg + CW'(1);
                    rv_next   = 1'b1;
                end
                if (rv_reg)
                begin
                    sum_next  = sum_reg + wpos;
                    wcnt_next = wcnt_reg + CW'(1);
                    if (!found_reg && target_reg <= {sum_reg + wpos, 16'd0})
                    begin
                        found_next = 1'b1;
                        pick_next  = wcnt_reg[AW-1:0];
                    end
                    if (wcnt_reg == last)
                    begin
                        rv_next    = 1'b0;
                        state_next = ST_PENAL;
                        rcnt_next  = '0;
                        gain_next  = -cap_gain(pen_wide);
                    end
                end
                rd_addr = (rv_next && rcnt_reg < n) ? rcnt_reg[AW-1:0] : pick_next;
            end
            ST_PENAL:
            begin
                // Read issued last cycle at pick and again on first visit; penalise on second.
                if (!rv_reg && rcnt_reg == '0)
                begin
                    rd_addr   = pick_reg;
                    rcnt_next = CW'(1);
                    rv_next   = 1'b1;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = pick_reg;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_FILL;
            rcnt_reg     <= '0;
            wcnt_reg     <= '0;
            rv_reg       <= 1'b0;
            done_reg     <= 1'b0;
            boost_reg    <= 1'b0;
            found_reg    <= 1'b0;
            fill_cmd_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rcnt_reg     <= rcnt_next;
            wcnt_reg     <= wcnt_next;
            rv_reg       <= rv_next;
            done_reg     <= done_next;
            boost_reg    <= boost_next;
            found_reg    <= found_next;
            fill_cmd_reg <= fill_cmd_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        gain_reg   <= gain_next;
        sum_reg    <= sum_next;
        maxw_reg   <= maxw_next;
        target_reg <= target_next;
        pick_reg   <= pick_next;
        if (state_reg == ST_IDLE && start)
        begin
            rnd_reg <= random_fraction;
            el_reg  <= elapsed_time;
        end
    end

    // Only a completed pick reports an index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            picked_reg <= 1'b0;
        else if (state_reg == ST_PENAL)
            picked_reg <= 1'b1;
        else if (state_reg == ST_IDLE && start)
            picked_reg <= 1'b0;
    end

    assign busy            = (state_reg != ST_IDLE) || done_reg;
    assign done            = done_reg;
    assign chosen_index    = (state_reg == ST_IDLE && picked_reg)
                             ? IndexOutBits'(32'(pick_reg)) : '0;
    assign weights_boosted = picked_reg ? boost_reg : 1'b0;

endmodule

// File: rtl/core/penalized_weighted_random_pick.sv
// Top level: configuration registers, input handshake and output register.
// Each transaction is handled by a sequencer around a weight memory with one write
// port and one registered read port. A pick makes one memory access per entry per
// pass over restore, sum, an optional boost followed by a second sum, and select;
// it forms the target before select and applies the penalty after it by reading
// and writing back the chosen word. A reset command, and a write of entry_count
// while idle, refill all MAX_ENTRIES words; the same fill runs once after reset,
// during which no transaction is accepted. A result waits in an output register.
module penalized_weighted_random_pick
    import pwrp_pkg::*;
#(
    parameter int MAX_ENTRIES = DefMaxEntries,
    parameter int WEIGHT_BITS = DefWeightBits
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CfgIdxBits-1:0]   cfg_index,
    input  logic [15:0]             cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    func,
    input  logic [15:0]             random_fraction,
    input  logic [15:0]             elapsed_time,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [IndexOutBits-1:0] chosen_index,
    output logic                    weights_boosted
);

    pwrp_cfg_t cfg_reg;
    logic      busy, done, fill_req;
    logic      out_valid_reg;
    logic [IndexOutBits-1:0] idx_reg;
    logic      boost_reg;
    logic [IndexOutBits-1:0] idx_w;
    logic      boost_w;
    logic      cfg_we;

    // Configuration registers.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign fill_req  = cfg_we && (cfg_index == CFG_ENTRY_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.entry_count       <= 7'd64;
            cfg_reg.time_based        <= 1'b0;
            cfg_reg.selection_penalty <= 16'd256;
            cfg_reg.restore_rate      <= 16'd64;
            cfg_reg.min_elapsed       <= 16'd0;
            cfg_reg.max_elapsed       <= 16'hFFFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENTRY_COUNT: cfg_reg.entry_count       <= cfg_data[6:0];
                CFG_TIME_BASED:  cfg_reg.time_based        <= cfg_data[0];
                CFG_PENALTY:     cfg_reg.selection_penalty <= cfg_data;
                CFG_RESTORE:     cfg_reg.restore_rate      <= cfg_data;
                CFG_MIN_ELAPSED: cfg_reg.min_elapsed       <= cfg_data;
                CFG_MAX_ELAPSED: cfg_reg.max_elapsed       <= cfg_data;
                default:         ;
            endcase
        end
    end

    // One transaction in flight; accept when idle, output slot free and no entry_count write.
    assign in_stall = busy || out_valid_reg || fill_req;

    pwrp_engine #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .fill_req        (fill_req),
        .start           (in_valid && !in_stall),
        .func            (func),
        .random_fraction (random_fraction),
        .elapsed_time    (elapsed_time),
        .busy            (busy),
        .done            (done),
        .chosen_index    (idx_w),
        .weights_boosted (boost_w)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (done)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            idx_reg   <= idx_w;
            boost_reg <= boost_w;
        end
    end

    assign out_valid       = out_valid_reg;
    assign chosen_index    = idx_reg;
    assign weights_boosted = boost_reg;

endmodule

// File: rtl/core/pwrp_checker.sv
// Port-level checker for the weighted random pick, with its bind.
`include "penalized_weighted_random_pick_assert.svh"
module pwrp_checker
    import pwrp_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic                    func,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic [IndexOutBits-1:0] chosen_index,
    input logic                    weights_boosted
);

    logic reset_cmd_reg;

    // Remember whether the transaction in flight is a reset command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            reset_cmd_reg <= 1'b0;
        else if (in_valid && !in_stall)
            reset_cmd_reg <= (func == FUNC_RESET);
    end

    // A reset command reports index zero and no boost.
    `PWRP_ASSERT_IMP(a_reset_zero, out_valid && reset_cmd_reg, chosen_index == '0 && !weights_boosted)

    // Once accepted, no new transaction is taken in the next cycle.
    `PWRP_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall)

    // A waiting result keeps the block from accepting.
    `PWRP_ASSERT_IMP(a_out_blocks, out_valid, in_stall)

    // A stalled result stays valid.
    `PWRP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(chosen_index))

endmodule

bind penalized_weighted_random_pick pwrp_checker u_pwrp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .func            (func),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .chosen_index    (chosen_index),
    .weights_boosted (weights_boosted)
);
